FILE: hdl/rsq_pkg.sv
package rsq_pkg;

    localparam int MAX_SPRITES      = 1024;
    localparam int VERTS_PER_SPRITE = 6;
    localparam int CNT_W            = 13;
    localparam int EXT_W            = 22;
    localparam int ZW               = 24;
    localparam int CW               = 32;
    localparam int PW               = 40;
    localparam int SW               = 43;
    localparam int ITERS            = 16;
    localparam int QUARTER_TURN     = 5760;
    localparam int HALF_TURN        = 11520;
    localparam int FULL_TURN        = 23040;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_SPRITES * VERTS_PER_SPRITE);
    localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd163008219;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_PUT   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_SC,
        ST_MUL,
        ST_CORN,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic                    opcode;
        logic signed [15:0]      pos_x;
        logic signed [15:0]      pos_y;
        logic [15:0]             pos_z;
        logic [EXT_W-1:0]        hw;
        logic [EXT_W-1:0]        hh;
        logic signed [ZW-1:0]    z0;
        logic                    neg;
        logic [31:0]             uv_start;
        logic [31:0]             uv_end;
        logic [31:0]             tint;
    } entry_t;

    typedef struct packed {
        logic signed [15:0] vtx_x;
        logic signed [15:0] vtx_y;
        logic [15:0]        vtx_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        color;
        logic [CNT_W-1:0]   vertex_index;
        logic               is_vertex;
        logic               accepted;
        logic               last;
    } vertex_t;

    function automatic logic signed [ZW-1:0] atan_val(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            4'd0:  r = 24'sd737280;
            4'd1:  r = 24'sd435242;
            4'd2:  r = 24'sd229970;
            4'd3:  r = 24'sd116736;
            4'd4:  r = 24'sd58595;
            4'd5:  r = 24'sd29326;
            4'd6:  r = 24'sd14666;
            4'd7:  r = 24'sd7334;
            4'd8:  r = 24'sd3667;
            4'd9:  r = 24'sd1833;
            4'd10: r = 24'sd917;
            4'd11: r = 24'sd458;
            4'd12: r = 24'sd229;
            4'd13: r = 24'sd115;
            4'd14: r = 24'sd57;
            default: r = 24'sd29;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/rsq_front.sv
module rsq_front
    import rsq_pkg::*;
(
    input  logic               in_valid,
    input  logic               q_full,
    input  logic               opcode,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [15:0]        pos_z,
    input  logic [9:0]         size_w,
    input  logic [9:0]         size_h,
    input  logic [11:0]        scale_w,
    input  logic [11:0]        scale_h,
    input  logic signed [15:0] angle,
    input  logic [31:0]        uv_start,
    input  logic [31:0]        uv_end,
    input  logic [31:0]        tint,
    output logic               in_stall,
    output logic               push,
    output entry_t             entry
);

    logic signed [17:0] t0, t1, t2, t3, t4, t5;
    logic               neg;

    always_comb
    begin
        t0 = {{2{angle[15]}}, angle} + 18'(QUARTER_TURN);
        t1 = (t0 < 0) ? t0 + 18'(FULL_TURN) : t0;
        t2 = (t1 < 0) ? t1 + 18'(FULL_TURN) : t1;
        t3 = (t2 >= 18'(FULL_TURN)) ? t2 - 18'(FULL_TURN) : t2;
        t4 = (t3 >= 18'(HALF_TURN)) ? t3 - 18'(FULL_TURN) : t3;
        neg = 1'b0;
        t5 = t4;
        if (t4 > 18'(QUARTER_TURN))
        begin
            t5 = t4 - 18'(HALF_TURN);
            neg = 1'b1;
        end
        else if (t4 < -18'(QUARTER_TURN))
        begin
            t5 = t4 + 18'(HALF_TURN);
            neg = 1'b1;
        end
    end

    always_comb
    begin
        entry.opcode   = opcode;
        entry.pos_x    = pos_x;
        entry.pos_y    = pos_y;
        entry.pos_z    = pos_z;
        entry.hw       = EXT_W'(size_w) * EXT_W'(scale_w);
        entry.hh       = EXT_W'(size_h) * EXT_W'(scale_h);
        entry.z0       = {t5[15:0], 8'b0};
        entry.neg      = neg;
        entry.uv_start = uv_start;
        entry.uv_end   = uv_end;
        entry.tint     = tint;
    end

    assign in_stall = q_full;
    assign push     = in_valid & ~q_full;

endmodule

FILE: hdl/rsq_queue.sv
module rsq_queue
    import rsq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_data,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t rd_data
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign rd_data   = mem_reg[rd_ptr_reg];

endmodule

FILE: hdl/rsq_back.sv
module rsq_back
    import rsq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             q_not_empty,
    input  entry_t           q_data,
    output logic             pop,
    input  logic             out_stall,
    output logic             out_valid,
    output vertex_t          out_item
);

    back_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]     count_reg;
    entry_t               work_reg;
    logic [3:0]           iter_reg;
    logic [2:0]           k_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [15:0]   s_reg, c_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [SW-1:0] cx_reg [4];
    logic signed [SW-1:0] cy_reg [4];
    logic                 out_valid_reg;
    vertex_t              out_reg;

    logic                 out_free;
    logic                 fits;
    logic                 load_status;
    logic                 start_put;
    logic                 load_vtx;
    logic signed [CW-1:0] x_sh, y_sh;
    logic signed [17:0]   xr, yr;
    logic signed [15:0]   s_val, c_val;
    logic [1:0]           q_sel;
    logic signed [SW-1:0] cent_x, cent_y;
    logic signed [SW-19-1:0] rx, ry;
    vertex_t              vtx;

    assign out_free = ~out_valid_reg | ~out_stall;
    assign fits = ({1'b0, count_reg} + (CNT_W+1)'(VERTS_PER_SPRITE)) <= {1'b0, limit_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty && out_free && q_data.opcode == OP_PUT && fits)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (iter_reg == 4'(ITERS - 1))
                begin
                    state_next = ST_SC;
                end
            end
            ST_SC:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_CORN;
            ST_CORN: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free && k_reg == 3'(VERTS_PER_SPRITE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        load_status = 1'b0;
        start_put   = 1'b0;
        load_vtx    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty && out_free)
                begin
                    pop = 1'b1;
                    if (q_data.opcode == OP_PUT && fits)
                    begin
                        start_put = 1'b1;
                    end
                    else
                    begin
                        load_status = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                load_vtx = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // rounding of the rotated unit vector
    always_comb
    begin
        x_sh = x_reg >>> iter_reg;
        y_sh = y_reg >>> iter_reg;
        xr = 18'((x_reg + 32'sd8192) >>> 14);
        yr = 18'((y_reg + 32'sd8192) >>> 14);
        if (xr > 18'sd16384)
        begin
            xr = 18'sd16384;
        end
        else if (xr < -18'sd16384)
        begin
            xr = -18'sd16384;
        end
        if (yr > 18'sd16384)
        begin
            yr = 18'sd16384;
        end
        else if (yr < -18'sd16384)
        begin
            yr = -18'sd16384;
        end
        c_val = work_reg.neg ? -xr[15:0] : xr[15:0];
        s_val = work_reg.neg ? -yr[15:0] : yr[15:0];
    end

    // vertex assembly
    always_comb
    begin
        unique case (k_reg)
            3'd0, 3'd3: q_sel = 2'd0;
            3'd1:       q_sel = 2'd1;
            3'd2, 3'd4: q_sel = 2'd2;
            default:    q_sel = 2'd3;
        endcase
        rx = (SW-19)'(cx_reg[q_sel] >>> 19);
        ry = (SW-19)'(cy_reg[q_sel] >>> 19);
        vtx.vtx_x = (rx > 24'sd32767) ? 16'sh7fff :
                    (rx < -24'sd32768) ? 16'sh8000 : rx[15:0];
        vtx.vtx_y = (ry > 24'sd32767) ? 16'sh7fff :
                    (ry < -24'sd32768) ? 16'sh8000 : ry[15:0];
        vtx.vtx_z = work_reg.pos_z;
        vtx.tex_u = (q_sel == 2'd0 || q_sel == 2'd3) ? work_reg.uv_start[31:16]
                                                     : work_reg.uv_end[31:16];
        vtx.tex_v = (q_sel == 2'd0 || q_sel == 2'd1) ? work_reg.uv_start[15:0]
                                                     : work_reg.uv_end[15:0];
        vtx.color        = work_reg.tint;
        vtx.vertex_index = count_reg + CNT_W'(k_reg);
        vtx.is_vertex    = 1'b1;
        vtx.accepted     = 1'b1;
        vtx.last         = (k_reg == 3'(VERTS_PER_SPRITE - 1));
        cent_x = SW'(work_reg.pos_x) <<< 19;
        cent_y = SW'(work_reg.pos_y) <<< 19;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            if (load_status || load_vtx)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_status && q_data.opcode == OP_BEGIN)
            begin
                count_reg <= '0;
            end
            if (start_put)
            begin
                iter_reg <= '0;
                k_reg    <= '0;
            end
            if (state_reg == ST_ROT)
            begin
                iter_reg <= iter_reg + 4'd1;
            end
            if (load_vtx)
            begin
                k_reg <= k_reg + 3'd1;
                if (k_reg == 3'(VERTS_PER_SPRITE - 1))
                begin
                    count_reg <= count_reg + CNT_W'(VERTS_PER_SPRITE);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_put)
        begin
            work_reg <= q_data;
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= q_data.z0;
        end
        if (state_reg == ST_ROT)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val(iter_reg);
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val(iter_reg);
            end
        end
        if (state_reg == ST_SC)
        begin
            s_reg <= s_val;
            c_reg <= c_val;
        end
        if (state_reg == ST_MUL)
        begin
            p1_reg <= PW'($signed({1'b0, work_reg.hw}) * s_reg);
            p2_reg <= PW'($signed({1'b0, work_reg.hw}) * c_reg);
            p3_reg <= PW'($signed({1'b0, work_reg.hh}) * s_reg);
            p4_reg <= PW'($signed({1'b0, work_reg.hh}) * c_reg);
        end
        if (state_reg == ST_CORN)
        begin
            cx_reg[0] <= -SW'(p1_reg) - SW'(p4_reg) + cent_x + SW'(262144);
            cy_reg[0] <=  SW'(p2_reg) - SW'(p3_reg) + cent_y + SW'(262144);
            cx_reg[1] <=  SW'(p1_reg) - SW'(p4_reg) + cent_x + SW'(262144);
            cy_reg[1] <= -SW'(p2_reg) - SW'(p3_reg) + cent_y + SW'(262144);
            cx_reg[2] <=  SW'(p1_reg) + SW'(p4_reg) + cent_x + SW'(262144);
            cy_reg[2] <= -SW'(p2_reg) + SW'(p3_reg) + cent_y + SW'(262144);
            cx_reg[3] <= -SW'(p1_reg) + SW'(p4_reg) + cent_x + SW'(262144);
            cy_reg[3] <=  SW'(p2_reg) + SW'(p3_reg) + cent_y + SW'(262144);
        end
        if (load_status)
        begin
            out_reg          <= '0;
            out_reg.accepted <= (q_data.opcode == OP_BEGIN);
            out_reg.last     <= 1'b1;
        end
        else if (load_vtx)
        begin
            out_reg <= vtx;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: hdl/rotated_sprite_quad_expander.sv
// Expands each put item (a rotated, scaled sprite) into six vertices, two triangles
// sharing the v0-v2 diagonal, written to consecutive buffer slots; a begin item
// clears the slot counter and a put that would overrun vertex_limit is answered
// with one status item (accepted low). A two-entry queue sits between the input
// side and the vertex engine. In the engine a put is taken from the queue, then runs
// through the single CORDIC stage, iterated for sine and cosine, then rounding, the
// extent multiplies and the corner sums, then yields one vertex per cycle while the
// output is not stalled. Begin and rejected puts yield only a status item.
module rotated_sprite_quad_expander
    import rsq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [15:0]        pos_z,
    input  logic [9:0]         size_w,
    input  logic [9:0]         size_h,
    input  logic [11:0]        scale_w,
    input  logic [11:0]        scale_h,
    input  logic signed [15:0] angle,
    input  logic [31:0]        uv_start,
    input  logic [31:0]        uv_end,
    input  logic [31:0]        tint,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] vtx_x,
    output logic signed [15:0] vtx_y,
    output logic [15:0]        vtx_z,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [31:0]        color,
    output logic [12:0]        vertex_index,
    output logic               is_vertex,
    output logic               accepted,
    output logic               last
);

    logic    push, pop, q_full, q_not_empty;
    entry_t  wr_entry, rd_entry;
    vertex_t item;

    rsq_front u_front (
        .in_valid (in_valid),
        .q_full   (q_full),
        .opcode   (opcode),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .size_w   (size_w),
        .size_h   (size_h),
        .scale_w  (scale_w),
        .scale_h  (scale_h),
        .angle    (angle),
        .uv_start (uv_start),
        .uv_end   (uv_end),
        .tint     (tint),
        .in_stall (in_stall),
        .push     (push),
        .entry    (wr_entry)
    );

    rsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_entry),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .rd_data   (rd_entry)
    );

    rsq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_data      (rd_entry),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_item    (item)
    );

    assign vtx_x        = item.vtx_x;
    assign vtx_y        = item.vtx_y;
    assign vtx_z        = item.vtx_z;
    assign tex_u        = item.tex_u;
    assign tex_v        = item.tex_v;
    assign color        = item.color;
    assign vertex_index = item.vertex_index;
    assign is_vertex    = item.is_vertex;
    assign accepted     = item.accepted;
    assign last         = item.last;

endmodule

FILE: sim/tb_rotated_sprite_quad_expander.sv
`timescale 1ns / 100ps

module tb_rotated_sprite_quad_expander;
    import rsq_pkg::*;

    typedef struct {
        logic        opcode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [9:0]  size_w;
        logic [9:0]  size_h;
        logic [11:0] scale_w;
        logic [11:0] scale_h;
        logic [15:0] angle;
        logic [31:0] uv_start;
        logic [31:0] uv_end;
        logic [31:0] tint;
    } sprite_t;

    typedef struct {
        logic        is_cfg;
        logic [12:0] limit;
        sprite_t     spr;
    } job_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [12:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = 1'b0;
    logic signed [15:0] pos_x = '0, pos_y = '0, angle = '0;
    logic [15:0] pos_z = '0;
    logic [9:0] size_w = '0, size_h = '0;
    logic [11:0] scale_w = '0, scale_h = '0;
    logic [31:0] uv_start = '0, uv_end = '0, tint = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] vtx_x, vtx_y;
    logic [15:0] vtx_z, tex_u, tex_v;
    logic [31:0] color;
    logic [12:0] vertex_index;
    logic is_vertex, accepted, last;

    rotated_sprite_quad_expander dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .size_w(size_w),
        .size_h(size_h), .scale_w(scale_w), .scale_h(scale_h), .angle(angle),
        .uv_start(uv_start), .uv_end(uv_end), .tint(tint),
        .out_valid(out_valid), .out_stall(out_stall), .vtx_x(vtx_x),
        .vtx_y(vtx_y), .vtx_z(vtx_z), .tex_u(tex_u), .tex_v(tex_v),
        .color(color), .vertex_index(vertex_index), .is_vertex(is_vertex),
        .accepted(accepted), .last(last)
    );

    always #5 clk = ~clk;

    job_t        pending[$];
    vertex_t     expected_vertices[$];
    logic [12:0] slot_limit;
    logic [12:0] slot_count;
    int          errors;
    int          puts_done;
    int          rejects_seen;
    int          vertices_seen;
    bit          stim_done;
    bit          hold_sender;
    bit          in_took = 1'b0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic rotate_sin_cos(input int theta, output longint s, output longint c);
        int t;
        bit neg;
        longint x, y, z, nx;
        longint atans[16];
        atans = '{737280, 435242, 229970, 116736, 58595, 29326, 14666, 7334,
                  3667, 1833, 917, 458, 229, 115, 57, 29};
        t = theta % FULL_TURN;
        neg = 0;
        x = 163008219;
        y = 0;
        if (t < 0) t += FULL_TURN;
        if (t >= HALF_TURN) t -= FULL_TURN;
        if (t > QUARTER_TURN)
        begin
            t -= HALF_TURN;
            neg = 1;
        end
        else if (t < -QUARTER_TURN)
        begin
            t += HALF_TURN;
            neg = 1;
        end
        z = longint'(t) * 256;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= atans[i];
            end
            else
            begin
                nx = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += atans[i];
            end
            x = nx;
        end
        x = clip(shr_floor(x + 8192, 14), -16384, 16384);
        y = clip(shr_floor(y + 8192, 14), -16384, 16384);
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic logic [15:0] place_q4(longint corner, longint centre);
        longint sum;
        sum = corner + centre * 524288;
        return 16'(clip(shr_floor(sum + 262144, 19), -32768, 32767));
    endfunction

    task automatic predict_sprite(input sprite_t sp);
        vertex_t v;
        longint s, c, hw, hh, a, b, f, g, px, py;
        longint cx[4], cy[4];
        logic [15:0] cu[4], cv[4];
        int corner_of[6];
        corner_of = '{0, 1, 2, 0, 2, 3};
        v = '0;
        if (sp.opcode == OP_BEGIN)
        begin
            slot_count = '0;
            v.accepted = 1'b1;
            v.last = 1'b1;
            expected_vertices.push_back(v);
            return;
        end
        if (int'(slot_count) + VERTS_PER_SPRITE > int'(slot_limit))
        begin
            v.last = 1'b1;
            expected_vertices.push_back(v);
            return;
        end
        px = longint'($signed(sp.pos_x));
        py = longint'($signed(sp.pos_y));
        rotate_sin_cos(int'($signed(sp.angle)) + QUARTER_TURN, s, c);
        hw = longint'(sp.size_w) * longint'(sp.scale_w);
        hh = longint'(sp.size_h) * longint'(sp.scale_h);
        a = -hw * s;
        b = hw * c;
        f = -hh * s;
        g = hh * c;
        cx[0] = a - g;  cy[0] = b + f;  cu[0] = sp.uv_start[31:16]; cv[0] = sp.uv_start[15:0];
        cx[1] = -a - g; cy[1] = -b + f; cu[1] = sp.uv_end[31:16];   cv[1] = sp.uv_start[15:0];
        cx[2] = -a + g; cy[2] = -b - f; cu[2] = sp.uv_end[31:16];   cv[2] = sp.uv_end[15:0];
        cx[3] = a + g;  cy[3] = b - f;  cu[3] = sp.uv_start[31:16]; cv[3] = sp.uv_end[15:0];
        for (int k = 0; k < VERTS_PER_SPRITE; k++)
        begin
            v.vtx_x = place_q4(cx[corner_of[k]], px);
            v.vtx_y = place_q4(cy[corner_of[k]], py);
            v.vtx_z = sp.pos_z;
            v.tex_u = cu[corner_of[k]];
            v.tex_v = cv[corner_of[k]];
            v.color = sp.tint;
            v.vertex_index = slot_count + 13'(k);
            v.is_vertex = 1'b1;
            v.accepted = 1'b1;
            v.last = (k == VERTS_PER_SPRITE - 1);
            expected_vertices.push_back(v);
        end
        slot_count = slot_count + 13'(VERTS_PER_SPRITE);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic sprite_t rand_sprite();
        sprite_t sp;
        sp.opcode = OP_PUT;
        sp.pos_x = 16'($urandom);
        sp.pos_y = 16'($urandom);
        sp.pos_z = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            sp.size_w = 10'($urandom);
            sp.size_h = 10'($urandom);
            sp.scale_w = 12'($urandom);
            sp.scale_h = 12'($urandom);
        end
        else
        begin
            sp.size_w = 10'($urandom_range(0, 64));
            sp.size_h = 10'($urandom_range(0, 64));
            sp.scale_w = 12'($urandom_range(0, 512));
            sp.scale_h = 12'($urandom_range(0, 512));
        end
        sp.angle = 16'($urandom);
        sp.uv_start = $urandom;
        sp.uv_end = $urandom;
        sp.tint = $urandom;
        return sp;
    endfunction

    function automatic job_t put_job(input sprite_t sp);
        job_t j;
        j.is_cfg = 0;
        j.limit = '0;
        j.spr = sp;
        return j;
    endfunction

    function automatic job_t cfg_job(input logic [12:0] lim);
        job_t j;
        j.is_cfg = 1;
        j.limit = lim;
        j.spr = '{default: '0};
        return j;
    endfunction

    // input handshake seen at the rising edge
    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && !in_stall;
    end

    // driver
    int send_gap = 0;
    always @(negedge clk)
    begin
        job_t j;
        cfg_write <= 1'b0;
        if (rst_n && (!in_valid || in_took))
        begin
            if (in_valid)
            begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            end
            else if (send_gap > 0)
                send_gap--;
            else if (pending.size() > 0 && !hold_sender)
            begin
                if (pending[0].is_cfg)
                begin
                    if (expected_vertices.size() == 0)
                    begin
                        j = pending.pop_front();
                        cfg_write <= 1'b1;
                        cfg_data <= j.limit;
                        slot_limit = j.limit;
                        send_gap = 40;
                    end
                end
                else
                begin
                    j = pending.pop_front();
                    predict_sprite(j.spr);
                    in_valid <= 1'b1;
                    opcode <= j.spr.opcode;
                    pos_x <= j.spr.pos_x;
                    pos_y <= j.spr.pos_y;
                    pos_z <= j.spr.pos_z;
                    size_w <= j.spr.size_w;
                    size_h <= j.spr.size_h;
                    scale_w <= j.spr.scale_w;
                    scale_h <= j.spr.scale_h;
                    angle <= j.spr.angle;
                    uv_start <= j.spr.uv_start;
                    uv_end <= j.spr.uv_end;
                    tint <= j.spr.tint;
                end
            end
            else if (pending.size() == 0)
                stim_done = 1;
        end
    end

    // receiver stall
    int recv_wait = 0;
    always @(negedge clk)
    begin
        if (recv_wait > 0)
        begin
            recv_wait--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && !out_stall)
                recv_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vertex_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                errors++;
                $display("unexpected item at %0t", $realtime);
            end
            else
            begin
                w = expected_vertices.pop_front();
                if (vtx_x !== w.vtx_x) report("vtx_x", 32'(vtx_x), 32'(w.vtx_x));
                if (vtx_y !== w.vtx_y) report("vtx_y", 32'(vtx_y), 32'(w.vtx_y));
                if (vtx_z !== w.vtx_z) report("vtx_z", 32'(vtx_z), 32'(w.vtx_z));
                if (tex_u !== w.tex_u) report("tex_u", 32'(tex_u), 32'(w.tex_u));
                if (tex_v !== w.tex_v) report("tex_v", 32'(tex_v), 32'(w.tex_v));
                if (color !== w.color) report("color", color, w.color);
                if (vertex_index !== w.vertex_index)
                    report("vertex_index", 32'(vertex_index), 32'(w.vertex_index));
                if (is_vertex !== w.is_vertex)
                    report("is_vertex", 32'(is_vertex), 32'(w.is_vertex));
                if (accepted !== w.accepted)
                    report("accepted", 32'(accepted), 32'(w.accepted));
                if (last !== w.last) report("last", 32'(last), 32'(w.last));
                if (is_vertex === 1'b1) vertices_seen++;
                else if (accepted === 1'b0) rejects_seen++;
            end
        end
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        sprite_t sp;
        logic [12:0] lims[4];
        errors = 0;
        vertices_seen = 0;
        rejects_seen = 0;
        stim_done = 0;
        hold_sender = 0;
        slot_limit = LIMIT_RESET;
        slot_count = '0;
        lims = '{13'd0, 13'd8191, 13'd36, 13'd6144};

        // directed
        sp = '{default: '0};
        pending.push_back(put_job(sp));
        sp.opcode = OP_BEGIN;
        pending.push_back(put_job(sp));
        sp = '{OP_PUT, 16'h7fff, 16'h7fff, 16'hffff, 10'h3ff, 10'h3ff, 12'hfff, 12'hfff,
               16'h5a00, 32'hffffffff, 32'hffffffff, 32'hffffffff};
        pending.push_back(put_job(sp));
        sp.pos_x = 16'h8000;
        sp.pos_y = 16'h8000;
        sp.angle = 16'h8000;
        pending.push_back(put_job(sp));
        foreach (lims[i])
        begin
            sp = rand_sprite();
            sp.angle = 16'(i * QUARTER_TURN - 11520);
            pending.push_back(put_job(sp));
        end
        sp = rand_sprite();
        sp.angle = 16'sd23039;
        pending.push_back(put_job(sp));
        sp.angle = -16'sd23040;
        pending.push_back(put_job(sp));
        pending.push_back(cfg_job(13'd12));
        for (int i = 0; i < 3; i++)
            pending.push_back(put_job(rand_sprite()));
        sp.opcode = OP_BEGIN;
        pending.push_back(put_job(sp));
        pending.push_back(put_job(rand_sprite()));

        // random phases over several limits
        for (int ph = 0; ph < 4; ph++)
        begin
            pending.push_back(cfg_job(lims[ph]));
            for (int i = 0; i < 85; i++)
            begin
                sp = rand_sprite();
                if ($urandom_range(0, 19) == 0)
                    sp.opcode = OP_BEGIN;
                pending.push_back(put_job(sp));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // drain once mid-run with the sender held
        wait (pending.size() < 200);
        hold_sender = 1;
        wait (expected_vertices.size() == 0);
        hold_sender = 0;

        wait (stim_done && expected_vertices.size() == 0 && !in_valid);
        repeat (60) @(posedge clk);
        $display("run covered %0d vertices and %0d rejected sprites", vertices_seen, rejects_seen);
        $display("limits swept from 0 to 8191 with random stalls on both sides");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rsq_pkg.sv
hdl/rsq_front.sv
hdl/rsq_queue.sv
hdl/rsq_back.sv
hdl/rotated_sprite_quad_expander.sv
sim/tb_rotated_sprite_quad_expander.sv
